@@ rtl/bbsf_pkg.sv @@
`default_nettype none
package bbsf_pkg;

    localparam int DEF_STORE_DEPTH = 1024;
    localparam int DEF_MAX_RUN     = 64;

    localparam int CAP_W  = 11;
    localparam int LEN_W  = 7;
    localparam int KIND_W = 3;
    localparam int BYTE_W = 8;
    localparam int TOT_W  = 64;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

    // Register index taken from paddr[2].
    localparam logic REG_CAPACITY = 1'b0;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 168;

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE = 3'd0,
        KIND_READ  = 3'd1,
        KIND_PEEK  = 3'd2,
        KIND_POP   = 3'd3,
        KIND_END   = 3'd4
    } kind_t;

endpackage
`default_nettype wire

@@ rtl/bbsf_ram.sv @@
`default_nettype none
module bbsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        // Read data holds while no read is issued.
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

@@ rtl/bounded_byte_stream_fifo_core.sv @@
`default_nettype none
// Write, pop, end, unknown, zero-byte read/peek: one result, in the cycle after the transfer;
// such items are taken one per cycle while the result port keeps up.
// Other read and peek: first byte via the memory read register and the output register, then
// one byte per cycle while the result port keeps up; the next item waits for the last byte.
// Reset (aresetn low, synchronous) clears head, count, totals, end flag and sets capacity to
// 1024; the byte memory is not cleared, as only written entries are ever read.
module bounded_byte_stream_fifo_core #(
    parameter int STORE_DEPTH = bbsf_pkg::DEF_STORE_DEPTH,
    parameter int MAX_RUN     = bbsf_pkg::DEF_MAX_RUN
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // s_tdata: data_byte[7:0], run_length[14:8], zero pad [15]
    input  wire logic [bbsf_pkg::S_TDATA_W-1:0]    s_tdata,
    // s_tuser: kind[2:0]
    input  wire logic [bbsf_pkg::KIND_W-1:0]       s_tuser,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // m_tdata: out_byte[7:0], accepted[8], buffered_count[19:9], free_space[30:20],
    // end_seen[31], end_of_stream[32], total_written[96:33], total_read[160:97], pad
    output logic      [bbsf_pkg::M_TDATA_W-1:0]    m_tdata,
    // m_tuser: byte_valid[0]
    output logic                                   m_tuser,
    output logic                                   m_tlast,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [bbsf_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [bbsf_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [bbsf_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam int WW = (CW > bbsf_pkg::CAP_W) ? CW : bbsf_pkg::CAP_W;
    localparam int LW = bbsf_pkg::LEN_W;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    state_t                       state_reg, state_next;
    logic [AW-1:0]                head_reg, head_next;
    logic [CW-1:0]                held_reg, held_next;
    logic [bbsf_pkg::TOT_W-1:0]   wtot_reg, wtot_next;
    logic [bbsf_pkg::TOT_W-1:0]   rtot_reg, rtot_next;
    logic                         ended_reg, ended_next;
    logic [bbsf_pkg::CAP_W-1:0]   cap_reg;
    logic [AW-1:0]                ptr_reg, ptr_next;
    logic [LW-1:0]                cnt_reg, cnt_next;
    logic                         is_read_reg, is_read_next;

    logic                         ovalid_reg, ovalid_next;
    logic [bbsf_pkg::BYTE_W-1:0]  obyte_reg, obyte_next;
    logic                         obv_reg, obv_next;
    logic                         oacc_reg, oacc_next;
    logic                         olast_reg, olast_next;

    // Input fields.
    bbsf_pkg::kind_t              kind;
    logic [bbsf_pkg::BYTE_W-1:0]  in_byte;
    logic [LW-1:0]                in_len;

    logic                         s_fire, out_free;
    logic [WW-1:0]                eff_cap, held_w, free_w, len_w, n_w;
    logic [LW-1:0]                len_cl, n;
    logic [AW:0]                  tail_sum, pop_sum;
    logic [AW-1:0]                tail_addr, pop_head, head_inc;

    logic                         ram_we, ram_re;
    logic [AW-1:0]                ram_raddr;
    logic [bbsf_pkg::BYTE_W-1:0]  ram_rdata;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
        logic [AW-1:0] r;
        if ({1'b0, a} == (AW+1)'(STORE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = a + AW'(1);
        end
        return r;
    endfunction

    function automatic logic [AW-1:0] wrap_sum(input logic [AW:0] s);
        logic [AW:0] r;
        if (s >= (AW+1)'(STORE_DEPTH)) begin
            r = s - (AW+1)'(STORE_DEPTH);
        end else begin
            r = s;
        end
        return r[AW-1:0];
    endfunction

    assign kind    = bbsf_pkg::kind_t'(s_tuser);
    assign in_byte = s_tdata[bbsf_pkg::BYTE_W-1:0];
    assign in_len  = s_tdata[bbsf_pkg::BYTE_W +: LW];

    assign out_free = !ovalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign s_fire   = s_tvalid && s_tready;

    // Effective capacity and free space.
    always_comb begin
        eff_cap = WW'(cap_reg);
        if (eff_cap > WW'(STORE_DEPTH)) begin
            eff_cap = WW'(STORE_DEPTH);
        end
        held_w = WW'(held_reg);
        free_w = (eff_cap > held_w) ? (eff_cap - held_w) : '0;
    end

    always_comb begin
        len_cl = (in_len > LW'(MAX_RUN)) ? LW'(MAX_RUN) : in_len;
        len_w  = WW'(len_cl);
        n_w    = (len_w < held_w) ? len_w : held_w;
        n      = n_w[LW-1:0];
    end

    assign tail_sum  = (AW+1)'(head_reg) + (AW+1)'(held_reg);
    assign tail_addr = wrap_sum(tail_sum);
    assign pop_sum   = (AW+1)'(head_reg) + (AW+1)'(n);
    assign pop_head  = wrap_sum(pop_sum);
    assign head_inc  = wrap_inc(head_reg);

    always_comb begin
        state_next   = state_reg;
        head_next    = head_reg;
        held_next    = held_reg;
        wtot_next    = wtot_reg;
        rtot_next    = rtot_reg;
        ended_next   = ended_reg;
        ptr_next     = ptr_reg;
        cnt_next     = cnt_reg;
        is_read_next = is_read_reg;
        ovalid_next  = ovalid_reg && !m_tready;
        obyte_next   = obyte_reg;
        obv_next     = obv_reg;
        oacc_next    = oacc_reg;
        olast_next   = olast_reg;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_raddr    = head_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    // Default: a single status result.
                    ovalid_next = 1'b1;
                    obyte_next  = '0;
                    obv_next    = 1'b0;
                    oacc_next   = 1'b0;
                    olast_next  = 1'b1;
                    case (kind)
                        bbsf_pkg::KIND_WRITE: begin
                            if (held_w < eff_cap) begin
                                ram_we    = 1'b1;
                                held_next = held_reg + CW'(1);
                                wtot_next = wtot_reg + 64'd1;
                                oacc_next = 1'b1;
                            end
                        end
                        bbsf_pkg::KIND_READ, bbsf_pkg::KIND_PEEK: begin
                            if (n != '0) begin
                                // The first byte is fetched now; the output register shows it.
                                ovalid_next  = 1'b0;
                                ram_re       = 1'b1;
                                ram_raddr    = head_reg;
                                ptr_next     = head_inc;
                                cnt_next     = n;
                                is_read_next = (kind == bbsf_pkg::KIND_READ);
                                state_next   = ST_EMIT;
                            end
                        end
                        bbsf_pkg::KIND_POP: begin
                            head_next = pop_head;
                            held_next = held_reg - CW'(n);
                            rtot_next = rtot_reg + 64'(n);
                        end
                        bbsf_pkg::KIND_END: begin
                            ended_next = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    ovalid_next = 1'b1;
                    obyte_next  = ram_rdata;
                    obv_next    = 1'b1;
                    oacc_next   = 1'b0;
                    olast_next  = (cnt_reg == LW'(1));
                    if (is_read_reg) begin
                        head_next = ptr_reg;
                        held_next = held_reg - CW'(1);
                        rtot_next = rtot_reg + 64'd1;
                    end
                    if (cnt_reg == LW'(1)) begin
                        state_next = ST_IDLE;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = ptr_reg;
                        ptr_next  = wrap_inc(ptr_reg);
                        cnt_next  = cnt_reg - LW'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            head_reg   <= '0;
            held_reg   <= '0;
            wtot_reg   <= '0;
            rtot_reg   <= '0;
            ended_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            held_reg   <= held_next;
            wtot_reg   <= wtot_next;
            rtot_reg   <= rtot_next;
            ended_reg  <= ended_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg     <= ptr_next;
        cnt_reg     <= cnt_next;
        is_read_reg <= is_read_next;
        obyte_reg   <= obyte_next;
        obv_reg     <= obv_next;
        oacc_reg    <= oacc_next;
        olast_reg   <= olast_next;
    end

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= bbsf_pkg::CAP_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == bbsf_pkg::REG_CAPACITY) begin
            cap_reg <= pwdata[bbsf_pkg::CAP_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == bbsf_pkg::REG_CAPACITY)
                  ? bbsf_pkg::APB_DATA_W'(cap_reg) : '0;

    bbsf_ram #(
        .WIDTH (bbsf_pkg::BYTE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (tail_addr),
        .wdata (in_byte),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Status fields reflect the state registers; but for free space, which tracks capacity
    // writes, they only change when the pending result is taken, matching the result shown.
    assign m_tvalid = ovalid_reg;
    assign m_tuser  = obv_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = {7'd0,
                       rtot_reg,
                       wtot_reg,
                       ended_reg && (held_reg == '0),
                       ended_reg,
                       free_w[bbsf_pkg::CAP_W-1:0],
                       held_w[bbsf_pkg::CAP_W-1:0],
                       oacc_reg,
                       obyte_reg};

endmodule
`default_nettype wire
